FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk outside reset.
`define CHK_PROP(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define CHK_NEVER(label, cond, msg) \
	`CHK_PROP(label, !(cond), msg)

`endif

FILE: sv/cit_pkg.sv
// ----------------------------------------------------------------------------
// cit_pkg
// Types and constants shared by the card identifier table.
// ----------------------------------------------------------------------------
package cit_pkg;

	localparam int NUM_SLOTS_DEF = 20;
	localparam int ID_W          = 64;
	localparam int SLOT_IDX_W    = 5;

	// Eight ASCII 'F' characters mark a free slot.
	localparam logic [ID_W-1:0] FREE_MARKER = 64'h4646_4646_4646_4646;

	localparam logic [1:0] FUNC_LOOKUP   = 2'd0;
	localparam logic [1:0] FUNC_REGISTER = 2'd1;
	localparam logic [1:0] FUNC_REMOVE   = 2'd2;
	localparam logic [1:0] FUNC_UNUSED   = 2'd3;

	typedef struct packed {
		logic [1:0]      func;
		logic [ID_W-1:0] card_id;
	} cit_req_t;

	typedef struct packed {
		logic                  success;
		logic [SLOT_IDX_W-1:0] slot_index;
	} cit_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} cit_state_t;

endpackage

FILE: sv/card_id_table_core.sv
// ----------------------------------------------------------------------------
// card_id_table_core
// Card identifier table: lookup, register into first free slot, remove first
// matching slot, scanning one slot per cycle through a shared comparator.
// ----------------------------------------------------------------------------
// Sequencing: an accepted item passes through the scan and response states; the
//   scan stops early on the first match, and an unused func skips the scan.
// Items are not overlapped: busy stays high until the done strobe ends, and the
//   next item is taken only from the idle state.
// The scan rate is set by the single slot memory read port and one comparator.
// Reset: arst_n clears the sequencer and marks every slot free at once.
// The done strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module card_id_table_core
	import cit_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cit_req_t req,
	output logic     done,
	output cit_rsp_t result
);

	localparam int              IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST  = IDX_W'(NUM_SLOTS - 1);

	cit_state_t       state_q, state_d;
	logic [1:0]       func_q;
	logic [ID_W-1:0]  key_q;     // value the scan compares against
	logic [ID_W-1:0]  wdata_q;   // value written on a hit
	logic [IDX_W-1:0] addr_q;    // next slot to read
	logic             issue_q;   // reads still to issue
	logic             vld_s1;    // read data valid for idx_s1
	logic [IDX_W-1:0] idx_s1;
	cit_rsp_t         result_q;

	logic             accept;
	logic             rd_en;
	logic [ID_W-1:0]  rd_data;
	logic             hit;
	logic             last_cmp;
	logic             wr_en;

	assign accept = start && (state_q == ST_IDLE);

	// Slot storage
	cit_store #(
		.NUM_SLOTS (NUM_SLOTS),
		.IDX_W     (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (idx_s1),
		.wr_data (wdata_q)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (req.func == FUNC_UNUSED) ? ST_RESP : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit || last_cmp) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		rd_en    = 1'b0;
		hit      = 1'b0;
		last_cmp = 1'b0;
		wr_en    = 1'b0;
		busy     = 1'b1;
		done     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_SCAN: begin
				rd_en    = issue_q;
				hit      = vld_s1 && (rd_data == key_q);
				last_cmp = vld_s1 && (idx_s1 == LAST);
				// Register and remove both rewrite the first hit slot.
				wr_en    = hit && ((func_q == FUNC_REGISTER) || (func_q == FUNC_REMOVE));
			end
			ST_RESP: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				issue_q <= 1'b1;
				vld_s1  <= 1'b0;
			end else begin
				// Drop issuing after the last slot or once the scan ends.
				if ((rd_en && (addr_q == LAST)) || state_d != ST_SCAN) begin
					issue_q <= 1'b0;
				end
				vld_s1 <= rd_en;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= req.func;
			// Register searches for a free slot; the others search for the id.
			key_q    <= (req.func == FUNC_REGISTER) ? FREE_MARKER : req.card_id;
			wdata_q  <= (req.func == FUNC_REMOVE) ? FREE_MARKER : req.card_id;
			addr_q   <= '0;
			result_q <= '0;
		end else begin
			if (rd_en) begin
				addr_q <= addr_q + IDX_W'(1);
				idx_s1 <= addr_q;
			end
			if (hit) begin
				result_q.success    <= 1'b1;
				result_q.slot_index <= SLOT_IDX_W'(idx_s1);
			end else if (last_cmp) begin
				result_q <= '0;
			end
		end
	end

	assign result = result_q;

	// Assertions
	`CHK_PROP(a_done_one_cycle, done |=> !done, "done strobe held longer than one cycle")
	`CHK_PROP(a_fail_zero_index, (done && !result.success) |-> (result.slot_index == '0),
		"failed result carries a nonzero slot index")
	`CHK_PROP(a_accept_busy, (start && !busy) |=> busy, "item accepted but busy not raised")
	`CHK_PROP(a_write_then_done, wr_en |=> (done && result.success),
		"slot written without a successful response next cycle")

endmodule

FILE: sv/cit_store.sv
// ----------------------------------------------------------------------------
// cit_store
// Slot memory with one write and one registered read port; a slot never
// written since reset reads as the free marker.
// ----------------------------------------------------------------------------
module cit_store
	import cit_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [ID_W-1:0]  rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [ID_W-1:0]  wr_data
);

	logic [ID_W-1:0]      mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] written_q;
	logic [ID_W-1:0]      mem_rd_q;
	logic                 written_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			written_rd_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				written_rd_q <= written_q[rd_addr];
			end
		end
	end

	// Untouched slots hold the free marker.
	assign rd_data = written_rd_q ? mem_rd_q : FREE_MARKER;

endmodule

FILE: tb/sv/card_id_table_core_tb.sv
// ----------------------------------------------------------------------------
// card_id_table_core_tb
// Self-checking bench for the card identifier table. A directed set of
// requests covers the marker, duplicates, the unused operation and the field
// extremes. Random phases then fill, drain and mix the table so that full
// tables, repeated identifiers and removes that hit or miss all occur. Each
// accepted request is run through a table model kept in the bench, and every
// done strobe is checked against the oldest predicted response.
// ----------------------------------------------------------------------------
module card_id_table_core_tb;
	import cit_pkg::*;

	localparam int NUM_SLOTS    = NUM_SLOTS_DEF;
	localparam int RANDOM_ITEMS = 1800;
	localparam int POOL_SIZE    = 28;
	localparam int MAX_PRINTS   = 50;

	// Directed identifiers: one ASCII card number and the two extremes.
	localparam logic [ID_W-1:0] ID_CARD  = "CARD0001";
	localparam logic [ID_W-1:0] ID_ZERO  = '0;
	localparam logic [ID_W-1:0] ID_ONES  = '1;

	// Phase kinds for the random part.
	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED
	} phase_kind_t;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	cit_req_t req    = '0;
	logic     busy;
	logic     done;
	cit_rsp_t result;

	// Requests waiting for the driver, and responses the table owes us.
	cit_req_t pend_reqs[$];
	cit_rsp_t owed_rsps[$];

	// Bench copy of the slot contents.
	logic [ID_W-1:0] card_slots[NUM_SLOTS];
	logic [ID_W-1:0] id_pool[POOL_SIZE];

	// Driver pacing.
	int burst_left = 0;
	int gap_left   = 0;

	// Run statistics.
	int err_count     = 0;
	int n_accepted    = 0;
	int n_checked     = 0;
	int lookup_hits   = 0;
	int remove_hits   = 0;
	int full_refusals = 0;
	int unused_ops    = 0;

	cit_rsp_t got_rsp;

	card_id_table_core #(
		.NUM_SLOTS(NUM_SLOTS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.result(result)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Table model
	// ------------------------------------------------------------------------

	// Scan from the top down so the lowest matching slot wins.
	function automatic int first_slot_holding(input logic [ID_W-1:0] key);
		int hit;
		hit = -1;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (card_slots[i] == key)
				hit = i;
		end
		return hit;
	endfunction

	// Apply one request to the table copy and return the response it owes.
	function automatic cit_rsp_t predict_table_op(input cit_req_t r);
		int       hit;
		cit_rsp_t rsp;
		hit = -1;
		case (r.func)
			FUNC_LOOKUP: begin
				hit = first_slot_holding(r.card_id);
				if (hit >= 0)
					lookup_hits++;
			end
			FUNC_REGISTER: begin
				hit = first_slot_holding(FREE_MARKER);
				if (hit >= 0)
					card_slots[hit] = r.card_id;
				else
					full_refusals++;
			end
			FUNC_REMOVE: begin
				hit = first_slot_holding(r.card_id);
				if (hit >= 0) begin
					card_slots[hit] = FREE_MARKER;
					remove_hits++;
				end
			end
			default: begin
				unused_ops++;
			end
		endcase
		rsp.success    = (hit >= 0);
		rsp.slot_index = (hit >= 0) ? hit[SLOT_IDX_W-1:0] : '0;
		return rsp;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	task automatic queue_request(input logic [1:0] func, input logic [ID_W-1:0] id);
		cit_req_t r;
		r.func    = func;
		r.card_id = id;
		pend_reqs.push_back(r);
	endtask

	function automatic logic [ID_W-1:0] rand_id();
		return {$urandom, $urandom};
	endfunction

	// Eight printable characters from '0' through 'Z'.
	function automatic logic [ID_W-1:0] ascii_id();
		logic [ID_W-1:0] id;
		id = '0;
		for (int b = 0; b < 8; b++)
			id = (id << 8) | ID_W'($urandom_range(8'h30, 8'h5A));
		return id;
	endfunction

	// Mostly identifiers from the pool so lookups and removes hit stored
	// entries; a few markers, extremes and fully random values.
	function automatic logic [ID_W-1:0] pick_id();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return id_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (roll < 80)
			return FREE_MARKER;
		else if (roll < 85)
			return ($urandom_range(0, 1) == 0) ? ID_ZERO : ID_ONES;
		else
			return rand_id();
	endfunction

	function automatic logic [1:0] pick_func(input phase_kind_t kind);
		int roll;
		roll = $urandom_range(0, 99);
		case (kind)
			PH_FILL: begin
				if (roll < 65)      return FUNC_REGISTER;
				else if (roll < 80) return FUNC_LOOKUP;
				else if (roll < 97) return FUNC_REMOVE;
			end
			PH_DRAIN: begin
				if (roll < 60)      return FUNC_REMOVE;
				else if (roll < 80) return FUNC_LOOKUP;
				else if (roll < 92) return FUNC_REGISTER;
			end
			default: begin
				if (roll < 33)      return FUNC_REGISTER;
				else if (roll < 66) return FUNC_LOOKUP;
				else if (roll < 96) return FUNC_REMOVE;
			end
		endcase
		return FUNC_UNUSED;
	endfunction

	// Print the first few mismatches, count all of them.
	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("ERROR t=%0t: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------------
	// Driver: present the head of the pending queue, hold it while busy,
	// and insert random gaps between bursts of requests.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			// An item moves when start meets a low busy; predict it now.
			if (start && !busy) begin
				owed_rsps.push_back(predict_table_op(req));
				void'(pend_reqs.pop_front());
				n_accepted++;
				if (burst_left != 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					// A third of the bursts follow on with no gap at all.
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				end
			end
			// Hold a request that is still waiting on busy; otherwise advance.
			if (!(start && busy)) begin
				if (gap_left != 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pend_reqs.size() != 0) begin
					start <= 1'b1;
					req   <= pend_reqs[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: every done strobe carries one response; it cannot be stalled,
	// so check it on the edge that ends the strobe.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_rsps.size() == 0) begin
				report_mismatch($sformatf("response with nothing owed: success=%0b slot=%0d",
					result.success, result.slot_index));
			end else begin
				got_rsp = owed_rsps.pop_front();
				if (result.success !== got_rsp.success)
					report_mismatch($sformatf("response %0d: success=%0b, want %0b",
						n_checked, result.success, got_rsp.success));
				if (result.slot_index !== got_rsp.slot_index)
					report_mismatch($sformatf("response %0d: slot_index=%0d, want %0d",
						n_checked, result.slot_index, got_rsp.slot_index));
				n_checked++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------------
	initial begin
		phase_kind_t kind;
		int          left;
		int          plen;

		for (int i = 0; i < NUM_SLOTS; i++)
			card_slots[i] = FREE_MARKER;
		// Half the pool is printable card numbers, half is arbitrary bits.
		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = (i % 2 == 0) ? ascii_id() : rand_id();

		// Directed: marker on an empty table, misses, extremes, a marker
		// register, duplicates, remove of the first duplicate, marker remove,
		// and the unused operation; the table ends empty again.
		queue_request(FUNC_LOOKUP,   FREE_MARKER);
		queue_request(FUNC_LOOKUP,   ID_ZERO);
		queue_request(FUNC_REMOVE,   ID_ONES);
		queue_request(FUNC_REGISTER, ID_ZERO);
		queue_request(FUNC_REGISTER, ID_ONES);
		queue_request(FUNC_REGISTER, FREE_MARKER);
		queue_request(FUNC_REGISTER, ID_CARD);
		queue_request(FUNC_REGISTER, ID_CARD);
		queue_request(FUNC_LOOKUP,   ID_CARD);
		queue_request(FUNC_REMOVE,   ID_CARD);
		queue_request(FUNC_LOOKUP,   ID_CARD);
		queue_request(FUNC_REMOVE,   FREE_MARKER);
		queue_request(FUNC_LOOKUP,   FREE_MARKER);
		queue_request(FUNC_UNUSED,   ID_CARD);
		queue_request(FUNC_UNUSED,   ID_ONES);
		queue_request(FUNC_LOOKUP,   ID_ZERO);
		queue_request(FUNC_LOOKUP,   ID_ONES);
		queue_request(FUNC_REMOVE,   ID_ZERO);
		queue_request(FUNC_REMOVE,   ID_ONES);
		queue_request(FUNC_REMOVE,   ID_CARD);

		// Random phases. The first one is a long fill so the table is
		// driven to full early; later phases pick fill, drain or mixed.
		left = RANDOM_ITEMS;
		kind = PH_FILL;
		plen = 40;
		while (left > 0) begin
			for (int k = 0; k < plen && left > 0; k++) begin
				queue_request(pick_func(kind), pick_id());
				left--;
			end
			kind = phase_kind_t'($urandom_range(0, 2));
			plen = $urandom_range(15, 70);
		end

		// Hold reset low at the start, then release it once.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the driver to empty its queue, then for every owed
		// response; sample on the falling edge to stay clear of the drivers.
		@(negedge clk);
		while (pend_reqs.size() != 0 || start)
			@(negedge clk);
		while (owed_rsps.size() != 0)
			@(negedge clk);
		// Let a stray extra strobe show up before closing.
		repeat (NUM_SLOTS + 8) @(negedge clk);

		$display("Covered %0d requests, %0d responses checked", n_accepted, n_checked);
		$display("Lookup hits %0d, remove hits %0d, full-table refusals %0d, unused ops %0d",
			lookup_hits, remove_hits, full_refusals, unused_ops);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Guard against a hung handshake: far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("ERROR: run timed out");
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/cit_pkg.sv
sv/cit_store.sv
sv/card_id_table_core.sv
tb/sv/card_id_table_core_tb.sv
